@@ hdl/tnnc_pkg.sv @@
// Shared constants for the threshold nearest-neighbour clustering block.
package tnnc_pkg;

  localparam int unsigned MAX_SEQUENCES_DEF = 4096;
  localparam int unsigned DISTANCE_BITS_DEF = 32;

  localparam int unsigned DIST_FIELD_W = 32;
  localparam int unsigned SEQ_FIELD_W  = 12;
  localparam int unsigned CFG_W        = 32;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic MODE_DISTANCE = 1'b0;
  localparam logic MODE_END_ROW  = 1'b1;

endpackage

@@ hdl/tnnc_front.sv @@
// Front end: accepts items, tracks row position, runs the threshold compare.
module tnnc_front import tnnc_pkg::*; #(
  parameter int unsigned MAX_SEQUENCES = MAX_SEQUENCES_DEF,
  parameter int unsigned DISTANCE_BITS = DISTANCE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [CFG_W-1:0]                 cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             mode,
  input  logic [DIST_FIELD_W-1:0]          distance,
  output logic                             push,
  output logic                             push_eor,
  output logic [$clog2(MAX_SEQUENCES)-1:0] push_pos,
  output logic [SEQ_FIELD_W-1:0]           push_seq,
  output logic                             push_ovf
);

  localparam int unsigned ID_W  = $clog2(MAX_SEQUENCES);
  localparam int unsigned CNT_W = $clog2(MAX_SEQUENCES + 1);
  localparam int unsigned CMP_W = (DISTANCE_BITS < DIST_FIELD_W) ? DISTANCE_BITS : DIST_FIELD_W;

  logic [CMP_W-1:0] threshold;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] pos;
  logic             accept;
  logic             below;
  logic             ovf;
  logic [CNT_W+SEQ_FIELD_W-1:0] cur_ext;

  assign accept  = in_valid && !in_stall;
  assign below   = distance[CMP_W-1:0] < threshold;
  assign ovf     = (cur == CNT_W'(MAX_SEQUENCES));
  assign cur_ext = (CNT_W+SEQ_FIELD_W)'(cur);

  // Only links and row ends matter to the back end; drop the rest here.
  assign push     = accept && ((mode == MODE_END_ROW) || ((pos < cur) && below));
  assign push_eor = (mode == MODE_END_ROW);
  assign push_pos = (mode == MODE_END_ROW) ? cur[ID_W-1:0] : pos[ID_W-1:0];
  assign push_seq = cur_ext[SEQ_FIELD_W-1:0];
  assign push_ovf = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      cur       <= '0;
      pos       <= '0;
    end else begin
      if (cfg_write) begin
        threshold <= cfg_data[CMP_W-1:0];
      end
      if (accept) begin
        if (mode == MODE_END_ROW) begin
          pos <= '0;
          if (!ovf) begin
            cur <= cur + 1'b1;
          end
        end else if (pos != CNT_W'(MAX_SEQUENCES)) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/tnnc_queue.sv @@
// Short register queue between the front and back ends.
module tnnc_queue import tnnc_pkg::*; #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/tnnc_back.sv @@
// Back end: cluster-id memory, running minimum, cluster count and result register.
module tnnc_back import tnnc_pkg::*; #(
  parameter int unsigned MAX_SEQUENCES = MAX_SEQUENCES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  logic                             q_eor,
  input  logic [$clog2(MAX_SEQUENCES)-1:0] q_pos,
  input  logic [SEQ_FIELD_W-1:0]           q_seq,
  input  logic                             q_ovf,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [SEQ_FIELD_W-1:0]           sequence_index,
  output logic [SEQ_FIELD_W-1:0]           cluster_id,
  output logic                             capacity_overflow
);

  localparam int unsigned ID_W  = $clog2(MAX_SEQUENCES);
  localparam int unsigned CNT_W = $clog2(MAX_SEQUENCES + 1);

  logic [ID_W-1:0] mem [MAX_SEQUENCES];
  logic [ID_W-1:0] rd_data;

  logic                   b_valid;
  logic                   b_eor;
  logic [ID_W-1:0]        b_pos;
  logic [SEQ_FIELD_W-1:0] b_seq;
  logic                   b_ovf;
  logic                   b_byp;
  logic [ID_W-1:0]        b_byp_data;

  logic             best_hit;
  logic [ID_W-1:0]  best;
  logic [CNT_W-1:0] count;

  logic                         out_free;
  logic                         b_ready;
  logic                         eor_done;
  logic                         wr_en;
  logic [CNT_W-1:0]             cid;
  logic [ID_W-1:0]              link_id;
  logic [CNT_W+SEQ_FIELD_W-1:0] cid_ext;

  assign out_free = !out_valid || !out_stall;
  assign b_ready  = !b_valid || !b_eor || out_free;
  assign q_pop    = q_valid && b_ready;
  assign eor_done = b_valid && b_eor && out_free;
  assign cid      = best_hit ? CNT_W'(best) : count;
  assign cid_ext  = (CNT_W+SEQ_FIELD_W)'(cid);
  assign wr_en    = eor_done && !b_ovf;
  // A read issued on the edge of a write sees the old entry; forward the new id.
  assign link_id  = b_byp ? b_byp_data : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[b_pos] <= cid[ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data    <= mem[q_pos];
      b_eor      <= q_eor;
      b_pos      <= q_pos;
      b_seq      <= q_seq;
      b_ovf      <= q_ovf;
      b_byp      <= wr_en && (b_pos == q_pos);
      b_byp_data <= cid[ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      sequence_index    <= b_seq;
      cluster_id        <= cid_ext[SEQ_FIELD_W-1:0];
      capacity_overflow <= b_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      best_hit  <= 1'b0;
      best      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid <= q_valid;
      end
      if (out_free) begin
        out_valid <= b_valid && b_eor;
      end
      if (b_valid && !b_eor) begin
        if (!best_hit || (link_id < best)) begin
          best     <= link_id;
          best_hit <= 1'b1;
        end
      end
      if (eor_done) begin
        best_hit <= 1'b0;
        if (!best_hit && !b_ovf && (count != CNT_W'(MAX_SEQUENCES))) begin
          count <= count + 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/threshold_nearest_neighbor_clustering.sv @@
// Top level of the threshold nearest-neighbour clustering block.
//
// Usage: sequences arrive in index order. For sequence i, send i distance
// transactions (mode 0) giving its distance to sequences 0..i-1 in order, then
// one end-of-row transaction (mode 1). The end of row yields one result
// transaction: sequence_index, cluster_id (lowest cluster holding a member
// strictly closer than distance_threshold, or a new one) and capacity_overflow.
// Input and output use valid/stall; a transaction moves when valid is high
// and stall is low. Write distance_threshold through cfg_write/cfg_data only
// while the block is idle.
// Throughput: one input transaction per cycle while the queue is not full,
// set by the one cluster memory read a cycle and the running-minimum compare
// in the back end. An end-of-row transaction passes through the queue, the
// memory read stage and the result register before its result appears.
// Reset (rst, synchronous) clears the counters, queue and threshold; there is
// no clearing pass over the cluster memory. When out_stall holds, the result
// register holds, the back end and then the four-entry queue fill, and
// in_stall rises once the queue is full.
module threshold_nearest_neighbor_clustering import tnnc_pkg::*; #(
  parameter int unsigned MAX_SEQUENCES = MAX_SEQUENCES_DEF,
  parameter int unsigned DISTANCE_BITS = DISTANCE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    mode,
  input  logic [DIST_FIELD_W-1:0] distance,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SEQ_FIELD_W-1:0]  sequence_index,
  output logic [SEQ_FIELD_W-1:0]  cluster_id,
  output logic                    capacity_overflow
);

  localparam int unsigned ID_W = $clog2(MAX_SEQUENCES);
  localparam int unsigned Q_W  = 1 + ID_W + SEQ_FIELD_W + 1;

  logic                   push;
  logic                   push_eor;
  logic [ID_W-1:0]        push_pos;
  logic [SEQ_FIELD_W-1:0] push_seq;
  logic                   push_ovf;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [Q_W-1:0]         q_head;

  // Stall the input only on a full queue, so a distance follows every cycle.
  assign in_stall = q_full;

  tnnc_front #(
    .MAX_SEQUENCES (MAX_SEQUENCES),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .distance  (distance),
    .push      (push),
    .push_eor  (push_eor),
    .push_pos  (push_pos),
    .push_seq  (push_seq),
    .push_ovf  (push_ovf)
  );

  // Queue entry: end-of-row flag, position (or own index), sequence field, overflow.
  tnnc_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_eor, push_pos, push_seq, push_ovf}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tnnc_back #(
    .MAX_SEQUENCES (MAX_SEQUENCES)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_eor             (q_head[Q_W-1]),
    .q_pos             (q_head[Q_W-2 -: ID_W]),
    .q_seq             (q_head[SEQ_FIELD_W:1]),
    .q_ovf             (q_head[0]),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sequence_index    (sequence_index),
    .cluster_id        (cluster_id),
    .capacity_overflow (capacity_overflow)
  );

endmodule

@@ bench/tnnc_assignment_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts cluster assignments and compares them with the block's results.
module tnnc_assignment_checker import tnnc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    mode,
  input  logic [DIST_FIELD_W-1:0] distance,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [SEQ_FIELD_W-1:0]  sequence_index,
  input  logic [SEQ_FIELD_W-1:0]  cluster_id,
  input  logic                    capacity_overflow,
  output int unsigned             mismatch_count,
  output int unsigned             assignments_owed
);

  localparam int unsigned CAPACITY = MAX_SEQUENCES_DEF;
  localparam logic [12:0] NO_LINK  = '1;

  typedef struct packed {
    logic [SEQ_FIELD_W-1:0] seq;
    logic [SEQ_FIELD_W-1:0] cid;
    logic                   overflow;
  } assignment_t;

  logic [CFG_W-1:0]       link_threshold;
  logic [SEQ_FIELD_W-1:0] cluster_mem [CAPACITY];
  logic [12:0]            row_seq;
  logic [12:0]            row_pos;
  logic [12:0]            row_best;
  logic [12:0]            clusters_open;
  assignment_t            owed_q [$];

  // One distance to the next earlier sequence: keep the lowest linked cluster.
  task automatic take_distance(input logic [DIST_FIELD_W-1:0] d);
    logic [12:0] c;
    if (row_pos < row_seq && row_pos < CAPACITY && d < link_threshold) begin
      c = {1'b0, cluster_mem[row_pos[11:0]]};
      if (row_best == NO_LINK || c < row_best) begin
        row_best = c;
      end
    end
    if (row_pos < CAPACITY) begin
      row_pos = row_pos + 1'b1;
    end
  endtask

  // End of row: join the linked cluster or open a new one, then queue the result.
  task automatic close_row();
    assignment_t a;
    logic [12:0] cid;
    logic        ovf;
    ovf = (row_seq >= CAPACITY);
    if (row_best != NO_LINK) begin
      cid = row_best;
    end else begin
      cid = clusters_open;
      if (!ovf && clusters_open < CAPACITY) begin
        clusters_open = clusters_open + 1'b1;
      end
    end
    if (!ovf) begin
      cluster_mem[row_seq[11:0]] = cid[11:0];
    end
    a.seq      = row_seq[11:0];
    a.cid      = cid[11:0];
    a.overflow = ovf;
    owed_q.insert(owed_q.size(), a);
    if (row_seq < CAPACITY) begin
      row_seq = row_seq + 1'b1;
    end
    row_pos  = '0;
    row_best = NO_LINK;
  endtask

  always @(posedge clk) begin : watch
    assignment_t due;
    if (rst) begin
      link_threshold = '0;
      row_seq        = '0;
      row_pos        = '0;
      row_best       = NO_LINK;
      clusters_open  = '0;
      owed_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write) begin
        link_threshold = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: sequence_index %0d cluster_id %0d",
                 sequence_index, cluster_id);
          mismatch_count++;
        end else begin
          due = owed_q.pop_front();
          if (sequence_index !== due.seq) begin
            $error("sequence_index: expected %0d, got %0d", due.seq, sequence_index);
            mismatch_count++;
          end
          if (cluster_id !== due.cid) begin
            $error("cluster_id: expected %0d, got %0d", due.cid, cluster_id);
            mismatch_count++;
          end
          if (capacity_overflow !== due.overflow) begin
            $error("capacity_overflow: expected %0d, got %0d",
                   due.overflow, capacity_overflow);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == MODE_END_ROW) begin
          close_row();
        end else begin
          take_distance(distance);
        end
      end
    end
    assignments_owed <= owed_q.size();
  end

endmodule

@@ bench/threshold_nearest_neighbor_clustering_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives rows of distances and thresholds into the clustering block.
module threshold_nearest_neighbor_clustering_tb;
  import tnnc_pkg::*;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_W-1:0]        cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    mode      = MODE_DISTANCE;
  logic [DIST_FIELD_W-1:0] distance  = '0;
  logic                    out_stall = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic [SEQ_FIELD_W-1:0]  sequence_index;
  logic [SEQ_FIELD_W-1:0]  cluster_id;
  logic                    capacity_overflow;
  int unsigned             mismatch_count;
  int unsigned             assignments_owed;

  // Stimulus bookkeeping: rows closed so far (earlier sequences for the next
  // row), transactions accepted, and the threshold currently loaded.
  int unsigned             rows_sent     = 0;
  int unsigned             items_sent    = 0;
  logic [CFG_W-1:0]        threshold_now = '0;
  // When set, neither side idles: gives back-to-back stretches.
  bit                      steady        = 1'b0;
  int                      stall_left    = 0;

  always #5 clk = ~clk;

  threshold_nearest_neighbor_clustering uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .distance          (distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sequence_index    (sequence_index),
    .cluster_id        (cluster_id),
    .capacity_overflow (capacity_overflow)
  );

  tnnc_assignment_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .distance          (distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sequence_index    (sequence_index),
    .cluster_id        (cluster_id),
    .capacity_overflow (capacity_overflow),
    .mismatch_count    (mismatch_count),
    .assignments_owed  (assignments_owed)
  );

  // Result side: after each accepted result, hold stall for a random wait unless steady is set.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin : draw_wait
      int n;
      n = steady ? 0 : int'($urandom_range(0, 3));
      out_stall  <= (n != 0);
      stall_left <= n;
    end else if (stall_left > 1) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end
  end

  // Offer one input transaction after a random gap and hold it until taken.
  // Valid stays high into the next call when that call draws no gap.
  task automatic offer(input logic m, input logic [DIST_FIELD_W-1:0] d);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    distance <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // Close the current row; the distance field carries junk that must be ignored.
  task automatic end_row();
    offer(MODE_END_ROW, $urandom);
    rows_sent++;
  endtask

  // Draw a distance around the threshold: exact edges, just below, just
  // above, the extremes, and mostly values that do not link.
  function automatic logic [DIST_FIELD_W-1:0] pick_distance();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return threshold_now - 1'b1;
      3: return threshold_now;
      4: return threshold_now + 1'b1;
      5: return (threshold_now == '0) ? '0 : $urandom_range(threshold_now - 1'b1);
      6: return $urandom;
      default: begin
        if (threshold_now == '1) begin
          return '1;
        end
        return threshold_now + 1'b1 + ($urandom % (32'hFFFF_FFFF - threshold_now));
      end
    endcase
  endfunction

  // Send distances to the first 'known' earlier sequences plus 'extras'
  // surplus distances, then end the row.
  task automatic send_row(input int unsigned known, input int unsigned extras);
    for (int unsigned p = 0; p < known + extras; p++) begin
      offer(MODE_DISTANCE, pick_distance());
    end
    end_row();
  endtask

  // Load a new threshold once the block has drained. Trailing distance
  // transactions give no result, so wait on past the last one before the write.
  task automatic set_threshold(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (assignments_owed != 0);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write     <= 1'b0;
    threshold_now  = v;
  endtask

  // Random rows: mostly complete rows while they are short, otherwise
  // truncated rows; now and then a complete row runs past its end.
  task automatic random_rows(input int unsigned budget);
    int unsigned target;
    int unsigned known;
    int unsigned extras;
    target = items_sent + budget;
    while (items_sent < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if (rows_sent <= 48 && $urandom_range(0, 9) < 7) begin
        known = rows_sent;
      end else begin
        known = $urandom_range(rows_sent < 48 ? rows_sent : 48);
      end
      extras = 0;
      if (known == rows_sent && $urandom_range(0, 7) == 0) begin
        extras = $urandom_range(1, 3);
      end
      send_row(known, extras);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows with threshold 1.0.
    set_threshold(32'h0001_0000);
    // First sequence: a surplus distance with no earlier sequence, ignored.
    offer(MODE_DISTANCE, '0);
    end_row();
    // Distance equal to the threshold does not link: open cluster 1.
    offer(MODE_DISTANCE, 32'h0001_0000);
    end_row();
    // Maximum distance, then one just below the threshold: join cluster 1.
    offer(MODE_DISTANCE, '1);
    offer(MODE_DISTANCE, 32'h0000_FFFF);
    end_row();
    // Zero distance links; the surplus zero afterwards is dropped.
    offer(MODE_DISTANCE, 32'h0001_0000);
    offer(MODE_DISTANCE, '1);
    offer(MODE_DISTANCE, '0);
    offer(MODE_DISTANCE, '0);
    end_row();
    // Truncated row linking to the first sequence: cluster 0.
    offer(MODE_DISTANCE, '0);
    end_row();
    // Links to cluster 1 first, then to cluster 0 later: lower cluster wins.
    offer(MODE_DISTANCE, '1);
    offer(MODE_DISTANCE, '0);
    offer(MODE_DISTANCE, '1);
    offer(MODE_DISTANCE, '1);
    offer(MODE_DISTANCE, 32'h0000_0001);
    end_row();

    // Random rows under several thresholds, extremes first.
    set_threshold('0);
    random_rows(170);
    set_threshold('1);
    random_rows(170);
    set_threshold(32'h0000_0001);
    random_rows(170);
    set_threshold($urandom);
    random_rows(190);
    set_threshold(32'h0004_0000);
    random_rows(190);
    set_threshold($urandom_range(32'h0002_0000));
    random_rows(190);

    // Drain, then allow for the pipeline before the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (assignments_owed != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
